// ===== rtl/fpba_pkg.sv =====
package fpba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int SIZE_BITS    = 20;
  localparam int ADDR_BITS    = 24;
  localparam int HEADER_BYTES = 32;
  localparam int HANDLE_BITS  = $clog2(MAX_BLOCKS);
  localparam int COUNT_BITS   = $clog2(MAX_BLOCKS + 1);
  localparam int GRANT_BITS   = SIZE_BITS + 1;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = ADDR_BITS;

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [GRANT_BITS-1:0]  grant_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_t;

  typedef enum logic [2:0] {
    ST_REUSED  = 3'd0,
    ST_GROWN   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_OOM     = 3'd3,
    ST_FREED   = 3'd4,
    ST_BADFREE = 3'd5
  } status_t;

  localparam logic CFG_IDX_POLICY = 1'b0;
  localparam logic CFG_IDX_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_READ,
    S_OUT
  } state_t;

  // Token passed along the cell chain during a search.
  typedef struct packed {
    logic    vld;
    handle_t idx;
    grant_t  size;
    logic    free;
  } tok_t;

  // Command from the controller to every cell.
  typedef struct packed {
    logic    shift;
    logic    load;
    logic    wr;
    handle_t wr_idx;
    grant_t  wr_size;
    logic    set_free;
    logic    clr_free;
    handle_t mark_idx;
  } cell_cmd_t;

endpackage

// ===== rtl/fpba_ram.sv =====
module fpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fpba_cell.sv =====
module fpba_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  fpba_pkg::handle_t   my_idx,
  input  fpba_pkg::cell_cmd_t cmd,
  input  fpba_pkg::tok_t      tok_in,
  output fpba_pkg::tok_t      tok_out
);
  import fpba_pkg::*;

  // Each cell owns one table entry: its size and free mark. During a search
  // the entries rotate around the ring, one hop per cycle.
  grant_t size_r, size_nxt;
  logic   free_r, free_nxt;
  tok_t   tok_r, tok_nxt;

  always_comb begin
    size_nxt = size_r;
    free_nxt = free_r;
    if (cmd.wr && cmd.wr_idx == my_idx) begin
      size_nxt = cmd.wr_size;
    end
    if (cmd.set_free && cmd.mark_idx == my_idx) begin
      free_nxt = 1'b1;
    end else if ((cmd.clr_free || cmd.wr) &&
                 ((cmd.clr_free && cmd.mark_idx == my_idx) ||
                  (cmd.wr && cmd.wr_idx == my_idx))) begin
      free_nxt = 1'b0;
    end
    tok_nxt = tok_r;
    if (cmd.load) begin
      tok_nxt = '{vld: 1'b1, idx: my_idx, size: size_r, free: free_r};
    end else if (cmd.shift) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      free_r <= free_nxt;
      tok_r  <= tok_nxt;
    end
    size_r <= size_nxt;
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/fpba_ctrl.sv =====
module fpba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [19:0]         in_request_size,
  input  logic [5:0]          in_block_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [5:0]          out_result_handle,
  output logic [23:0]         out_data_address,
  output logic [20:0]         out_granted_size,
  input  logic [1:0]          fit_policy,
  input  fpba_pkg::addr_t     heap_limit,
  input  fpba_pkg::tok_t      tok_head,
  output fpba_pkg::cell_cmd_t cmd
);
  import fpba_pkg::*;

  state_t  state_r, state_nxt;
  logic    op_r, op_nxt;
  grant_t  need_r, need_nxt;
  handle_t hnd_r, hnd_nxt;
  count_t  count_r, count_nxt;
  addr_t   top_r, top_nxt;
  handle_t cursor_r, cursor_nxt;
  count_t  step_r, step_nxt;
  logic    found_r, found_nxt;
  handle_t win_r, win_nxt;
  grant_t  wsize_r, wsize_nxt;
  logic    nf_hit_r, nf_hit_nxt;
  handle_t nf_idx_r, nf_idx_nxt;
  grant_t  nf_size_r, nf_size_nxt;
  logic    ovld_r, ovld_nxt;
  status_t ost_r, ost_nxt;
  handle_t oh_r, oh_nxt;
  addr_t   oa_r, oa_nxt;
  grant_t  os_r, os_nxt;
  logic    free_hit_r, free_hit_nxt;

  logic    ram_we;
  handle_t ram_waddr, ram_raddr;
  addr_t   ram_rdata;

  logic    fits, better, in_range;
  handle_t start;
  logic [ADDR_BITS:0] new_top;

  fpba_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_BLOCKS)) u_starts (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(top_r),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE) || ovld_r;
  assign start = ({1'b0, cursor_r} < count_r) ? cursor_r : '0;
  assign in_range = {1'b0, tok_head.idx} < count_r;
  assign fits = tok_head.vld && in_range && tok_head.free && (tok_head.size >= need_r);
  assign new_top = {1'b0, top_r} + (ADDR_BITS+1)'(HEADER_BYTES) + (ADDR_BITS+1)'(need_r);

  always_comb begin
    unique case (fit_t'(fit_policy))
      FIT_BEST:  better = tok_head.size < wsize_r;
      FIT_WORST: better = tok_head.size > wsize_r;
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; need_nxt = need_r; hnd_nxt = hnd_r;
    count_nxt = count_r; top_nxt = top_r; cursor_nxt = cursor_r;
    step_nxt = step_r; found_nxt = found_r; win_nxt = win_r; wsize_nxt = wsize_r;
    nf_hit_nxt = nf_hit_r; nf_idx_nxt = nf_idx_r; nf_size_nxt = nf_size_r;
    ovld_nxt = ovld_r; ost_nxt = ost_r; oh_nxt = oh_r; oa_nxt = oa_r; os_nxt = os_r;
    free_hit_nxt = free_hit_r;
    cmd = '0;
    ram_we = 1'b0; ram_waddr = count_r[HANDLE_BITS-1:0]; ram_raddr = win_r;
    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_operation;
          hnd_nxt = in_block_handle;
          need_nxt = (GRANT_BITS'(in_request_size) + GRANT_BITS'(3)) & ~GRANT_BITS'(3);
          if (!in_operation && in_request_size == '0) begin
            ovld_nxt = 1'b1; ost_nxt = ST_ZERO; oh_nxt = '0; oa_nxt = '0; os_nxt = '0;
          end else begin
            cmd.load = 1'b1;
            step_nxt = '0; found_nxt = 1'b0; nf_hit_nxt = 1'b0;
            free_hit_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.shift = 1'b1;
        if (op_r) begin
          if (tok_head.idx == hnd_r) begin
            free_hit_nxt = in_range && !tok_head.free;
            wsize_nxt = tok_head.size;
          end
        end else if (fits) begin
          if (fit_t'(fit_policy) == FIT_NEXT) begin
            if (tok_head.idx >= start && !found_r) begin
              found_nxt = 1'b1; win_nxt = tok_head.idx; wsize_nxt = tok_head.size;
            end
            if (tok_head.idx < start && !nf_hit_r) begin
              nf_hit_nxt = 1'b1; nf_idx_nxt = tok_head.idx; nf_size_nxt = tok_head.size;
            end
          end else if (!found_r || better) begin
            found_nxt = 1'b1; win_nxt = tok_head.idx; wsize_nxt = tok_head.size;
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == count_t'(MAX_BLOCKS - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (op_r) begin
          win_nxt = hnd_r;
          state_nxt = S_READ;
        end else if (found_r || nf_hit_r) begin
          if (!found_r) begin
            win_nxt = nf_idx_r; wsize_nxt = nf_size_r;
          end
          state_nxt = S_READ;
        end else if (count_r == count_t'(MAX_BLOCKS) ||
                     new_top > {1'b0, heap_limit}) begin
          ovld_nxt = 1'b1; ost_nxt = ST_OOM; oh_nxt = '0; oa_nxt = '0; os_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          ram_we = 1'b1;
          cmd.wr = 1'b1;
          cmd.wr_idx = count_r[HANDLE_BITS-1:0];
          cmd.wr_size = need_r;
          ovld_nxt = 1'b1; ost_nxt = ST_GROWN;
          oh_nxt = count_r[HANDLE_BITS-1:0];
          oa_nxt = top_r + ADDR_BITS'(HEADER_BYTES);
          os_nxt = need_r;
          cursor_nxt = count_r[HANDLE_BITS-1:0];
          count_nxt = count_r + 1'b1;
          top_nxt = new_top[ADDR_BITS-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ovld_nxt = 1'b1;
        oh_nxt = win_r;
        state_nxt = S_IDLE;
        if (op_r) begin
          if (free_hit_r) begin
            cmd.set_free = 1'b1; cmd.mark_idx = win_r;
            ost_nxt = ST_FREED; oa_nxt = ram_rdata + ADDR_BITS'(HEADER_BYTES);
            os_nxt = wsize_r;
          end else begin
            ost_nxt = ST_BADFREE; oa_nxt = '0; os_nxt = '0;
          end
        end else begin
          cmd.clr_free = 1'b1; cmd.mark_idx = win_r;
          cursor_nxt = win_r;
          ost_nxt = ST_REUSED; oa_nxt = ram_rdata + ADDR_BITS'(HEADER_BYTES);
          os_nxt = wsize_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; top_r <= '0; cursor_r <= '0; ovld_r <= 1'b0;
      found_r <= 1'b0; nf_hit_r <= 1'b0; free_hit_r <= 1'b0; step_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; top_r <= top_nxt;
      cursor_r <= cursor_nxt; ovld_r <= ovld_nxt; found_r <= found_nxt;
      nf_hit_r <= nf_hit_nxt; free_hit_r <= free_hit_nxt; step_r <= step_nxt;
    end
    op_r <= op_nxt; need_r <= need_nxt; hnd_r <= hnd_nxt; win_r <= win_nxt;
    wsize_r <= wsize_nxt; nf_idx_r <= nf_idx_nxt; nf_size_r <= nf_size_nxt;
    ost_r <= ost_nxt; oh_r <= oh_nxt; oa_r <= oa_nxt; os_r <= os_nxt;
  end

  assign out_valid = ovld_r;
  assign out_status = ost_r;
  assign out_result_handle = oh_r;
  assign out_data_address = oa_r;
  assign out_granted_size = os_r;

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Channel | Handshake           | Payload
// in      | in_valid/in_stall   | operation, request_size, block_handle
// out     | out_valid/out_stall | status, result_handle, data_address, granted_size
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// A zero-size allocate shows its result in the cycle after the transfer. Growth and
// out of memory wait for the entries to rotate once around the cell ring past the
// controller, then the decision; reuse and free add a start-address RAM read and the
// result.
// Reset clears the free marks, block count, heap top and cursor at once.
// A stalled result holds the block; the next item waits until it transfers.
module fit_policy_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [19:0] in_request_size,
  input  logic [5:0]  in_block_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_result_handle,
  output logic [23:0] out_data_address,
  output logic [20:0] out_granted_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [fpba_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fpba_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import fpba_pkg::*;

  logic [1:0] policy_r;
  addr_t      limit_r;
  cell_cmd_t  cmd;
  tok_t       tok [MAX_BLOCKS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= FIT_FIRST;
      limit_r  <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_POLICY: policy_r <= cfg_data[1:0];
        CFG_IDX_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    fpba_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(handle_t'(i)), .cmd(cmd),
      .tok_in(tok[(i + 1) % MAX_BLOCKS]), .tok_out(tok[i])
    );
  end

  fpba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_request_size(in_request_size), .in_block_handle(in_block_handle),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_result_handle(out_result_handle), .out_data_address(out_data_address),
    .out_granted_size(out_granted_size),
    .fit_policy(policy_r), .heap_limit(limit_r), .tok_head(tok[0]), .cmd(cmd)
  );

endmodule

// ===== rtl/fpba_checker.sv =====
module fpba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [23:0] out_data_address,
  input logic [20:0] out_granted_size
);
  import fpba_pkg::*;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second input taken while busy");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("stalled result dropped");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BADFREE) else $error("bad status code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ZERO || out_status == ST_OOM ||
                  out_status == ST_BADFREE)
      |-> out_data_address == '0 && out_granted_size == '0)
    else $error("failure result carries data");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_data_address(out_data_address), .out_granted_size(out_granted_size)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

import fpba_pkg::*;

typedef struct {
  status_t st;
  handle_t hdl;
  addr_t   addr;
  grant_t  grant;
} grant_rec_t;

class heap_scoreboard;
  fit_t           policy;
  addr_t          limit;
  grant_t         sizes[MAX_BLOCKS];
  addr_t          starts[MAX_BLOCKS];
  bit             freed[MAX_BLOCKS];
  int             count;
  addr_t          top;
  int             cursor;
  grant_rec_t     pending[$];
  int             errors;

  function new();
    policy = FIT_FIRST;
    limit  = '1;
    count  = 0;
    top    = '0;
    cursor = 0;
    errors = 0;
    foreach (freed[i]) freed[i] = 1'b0;
  endfunction

  task report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function int choose(grant_t need);
    int     win;
    longint slack;
    longint d;
    int     k;
    int     start;
    win   = MAX_BLOCKS;
    slack = 0;
    if (policy == FIT_NEXT) begin
      start = (cursor < count) ? cursor : 0;
      for (int i = 0; i < count; i++) begin
        k = (start + i) % count;
        if (freed[k] && sizes[k] >= need) return k;
      end
      return MAX_BLOCKS;
    end
    for (int i = 0; i < count; i++) begin
      if (!(freed[i] && sizes[i] >= need)) continue;
      if (policy == FIT_FIRST) return i;
      d = longint'(sizes[i]) - longint'(need);
      if (win == MAX_BLOCKS || (policy == FIT_BEST && d < slack) ||
          (policy == FIT_WORST && d > slack)) begin
        win   = i;
        slack = d;
      end
    end
    return win;
  endfunction

  function int live_handle();
    int live[$];
    for (int i = 0; i < count; i++) if (!freed[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function void note_request(logic op, logic [19:0] req, handle_t h);
    grant_rec_t r;
    grant_t     need;
    longint     new_top;
    int         k;
    r = '{ST_ZERO, '0, '0, '0};
    if (op == 1'b0) begin
      if (req != 0) begin
        need = ((grant_t'(req) + 3) >> 2) << 2;
        k = choose(need);
        if (k < count) begin
          freed[k] = 1'b0;
          cursor   = k;
          r = '{ST_REUSED, handle_t'(k), starts[k] + HEADER_BYTES, sizes[k]};
        end else begin
          new_top = longint'(top) + HEADER_BYTES + longint'(need);
          if (count >= MAX_BLOCKS || new_top > longint'(limit)) begin
            r.st = ST_OOM;
          end else begin
            k = count;
            sizes[k]  = need;
            starts[k] = top;
            freed[k]  = 1'b0;
            count++;
            top    = addr_t'(new_top);
            cursor = k;
            r = '{ST_GROWN, handle_t'(k), starts[k] + HEADER_BYTES, need};
          end
        end
      end
    end else begin
      if (h >= count || freed[h]) begin
        r = '{ST_BADFREE, h, '0, '0};
      end else begin
        freed[h] = 1'b1;
        r = '{ST_FREED, h, starts[h] + HEADER_BYTES, sizes[h]};
      end
    end
    pending.push_back(r);
  endfunction

  task check_grant(logic [2:0] st, handle_t h, addr_t a, grant_t g);
    grant_rec_t e;
    if (pending.size() == 0) begin
      report_mismatch("unexpected transfer, status", st, -1);
    end else begin
      e = pending.pop_front();
      if (st !== e.st) report_mismatch("status", st, e.st);
      if (h !== e.hdl) report_mismatch("result_handle", h, e.hdl);
      if (a !== e.addr) report_mismatch("data_address", a, e.addr);
      if (g !== e.grant) report_mismatch("granted_size", g, e.grant);
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN = 90;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [19:0] in_request_size;
  logic [5:0]  in_block_handle;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [5:0]  out_result_handle;
  logic [23:0] out_data_address;
  logic [20:0] out_granted_size;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  heap_scoreboard sb;
  int  cycles;
  int  hold_cycles;
  bit  quiet;

  fit_policy_block_allocator u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fit_policy_block_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_operation, in_request_size, in_block_handle);
    if (rst_n && out_valid && !out_stall)
      sb.check_grant(out_status, out_result_handle, out_data_address, out_granted_size);
  end

  initial begin
    int left;
    int r;
    bit level;
    left  = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 70) left = $urandom_range(1, 4);
          else if (r < 96) left = $urandom_range(5, 30);
          else left = $urandom_range(80, 300);
          level = $urandom_range(0, 2) == 0;
        end
        left--;
        out_stall <= level;
      end
    end
  end

  task automatic send(logic op, logic [19:0] req, logic [5:0] h);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 5);
    else gap = $urandom_range(20, 200);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_request_size <= req;
    in_block_handle <= h;
    do @(negedge clk); while (!(in_valid && !in_stall));
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_POLICY) sb.policy = fit_t'(val[1:0]);
    else sb.limit = val;
  endtask

  task automatic random_item();
    int r;
    int h;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      r = $urandom_range(0, 99);
      if (r < 5) send(1'b0, 20'd0, 6'($urandom));
      else if (r < 88) send(1'b0, 20'($urandom_range(1, 300)), 6'($urandom));
      else send(1'b0, 20'($urandom), 6'($urandom));
    end else begin
      h = sb.live_handle();
      if (h < 0 || $urandom_range(0, 4) == 0) h = $urandom_range(0, 63);
      send(1'b1, 20'($urandom), 6'(h));
    end
  endtask

  initial begin
    int pol[4];
    addr_t lims[4];
    sb = new();
    hold_cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_request_size = '0;
    in_block_handle = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_IDX_LIMIT, '0);
    send(1'b0, 20'd4, 6'd0);
    write_reg(CFG_IDX_LIMIT, '1);
    write_reg(CFG_IDX_POLICY, FIT_FIRST);
    send(1'b0, 20'd0, 6'd63);
    send(1'b0, 20'd1, 6'd0);
    send(1'b0, 20'hFFFFF, 6'd0);
    send(1'b0, 20'd5, 6'd0);
    send(1'b0, 20'd8, 6'd0);
    send(1'b0, 20'd64, 6'd0);
    send(1'b1, 20'hFFFFF, 6'd63);
    send(1'b1, 20'd0, 6'd1);
    send(1'b1, 20'd0, 6'd1);
    send(1'b1, 20'd0, 6'd3);
    send(1'b1, 20'd0, 6'd4);
    send(1'b1, 20'd0, 6'd0);
    send(1'b0, 20'd3, 6'd0);
    send(1'b0, 20'd7, 6'd0);
    send(1'b0, 20'd951424, 6'd0);
    send(1'b1, 20'd0, 6'd4);
    send(1'b1, 20'd0, 6'd5);

    quiet = 1'b1;
    hold_cycles = 400;
    repeat (6) random_item();
    quiet = 1'b0;

    pol  = '{FIT_BEST, FIT_WORST, FIT_NEXT, FIT_FIRST};
    lims = '{24'h00FFFF, 24'h3FFFFF, 24'hFFFFFF, 24'h000400};
    foreach (pol[p]) begin
      write_reg(CFG_IDX_POLICY, pol[p][1:0]);
      write_reg(CFG_IDX_LIMIT, lims[p]);
      for (int i = 0; i < 130; i++) begin
        if (i == 60) quiet = 1'b1;
        if (i == 90) quiet = 1'b0;
        random_item();
      end
    end
    settle();

    if (sb.pending.size() != 0) sb.report_mismatch("results missing", 0, sb.pending.size());
    if (sb.errors == 0) begin
      $display("PASS fit_policy_block_allocator");
    end else begin
      $display("FAIL fit_policy_block_allocator");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_cell.sv
rtl/fpba_ctrl.sv
rtl/fit_policy_block_allocator.sv
rtl/fpba_checker.sv
verif/tb.sv
